>>> hw/rtl/ppk_pkg.sv
// ----------------------------------------------------------------------------
// ppk_pkg: shared types and constants for the RGB pixel packer
// Holds field widths, the queue entry type and the width saturation helper.
// ----------------------------------------------------------------------------
package ppk_pkg;

    localparam int CHAN_BITS    = 8;   // width of one input colour channel
    localparam int NUM_CHANNELS = 3;
    localparam int BYTE_BITS    = 8;
    localparam int CFG_BITS     = 4;   // width of the kept-width register
    localparam int PEND_BITS    = 7;   // leftover bits that never form a byte
    localparam int PCNT_BITS    = 3;   // holds a leftover count of 0..7
    localparam int PACK_BITS    = NUM_CHANNELS * CHAN_BITS;  // 24
    localparam int ACC_BITS     = PEND_BITS + PACK_BITS;     // 31
    localparam int SUM_BITS     = 5;   // holds a bit total of 0..31
    localparam int NBYTE_BITS   = 3;   // holds a byte count of 0..4
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_BITS-1:0] KEEP_WIDTH_RESET = CFG_BITS'(8);

    // One packed pixel handed from the front to the back.
    typedef struct packed {
        logic [ACC_BITS-1:0]   acc;     // stream bits, zero above the valid ones
        logic [NBYTE_BITS-1:0] nbytes;  // bytes to emit, 1..4
        logic                  last;    // final byte closes the image
    } ppk_entry_t;

    // Saturate the configured width into 1..8.
    function automatic logic [CFG_BITS-1:0] eff_width(input logic [CFG_BITS-1:0] cfg);
        logic [CFG_BITS-1:0] w;
        w = cfg;
        if (cfg == '0)
        begin
            w = CFG_BITS'(1);
        end
        else if (cfg > CFG_BITS'(BYTE_BITS))
        begin
            w = CFG_BITS'(BYTE_BITS);
        end
        return w;
    endfunction

endpackage

>>> hw/rtl/ppk_if.sv
// ----------------------------------------------------------------------------
// ppk_if: channel interfaces of the RGB pixel packer
// Pixel input, byte output and configuration write channels.
// ----------------------------------------------------------------------------

// Pixel channel: one RGB pixel per transaction.
interface ppk_pixel_if import ppk_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic                 last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

// Byte channel: one packed byte per transaction.
interface ppk_byte_if import ppk_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// Configuration channel: one write of the kept channel width per transaction.
interface ppk_cfg_if import ppk_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/ppk_front.sv
// ----------------------------------------------------------------------------
// ppk_front: pixel intake and bit packing
// Reduces each channel, appends the pixel to the leftover bits and hands
// every pixel that completes a byte, and every last pixel with bits to flush, to the queue as one entry.
// ----------------------------------------------------------------------------
module ppk_front import ppk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ppk_pixel_if.sink   pixel,
    ppk_cfg_if.sink     cfg,
    input  logic        q_full,
    output logic        q_push,
    output ppk_entry_t  q_entry
);

    logic [CFG_BITS-1:0]  keep_width_reg;
    logic [PEND_BITS-1:0] pending_bits_reg, pending_bits_next;
    logic [PCNT_BITS-1:0] pending_count_reg, pending_count_next;

    logic [CFG_BITS-1:0]   w;
    logic [CFG_BITS-1:0]   drop;
    logic [CHAN_BITS-1:0]  r, g, b;
    logic [PACK_BITS-1:0]  packed_px;
    logic [ACC_BITS-1:0]   acc;
    logic [SUM_BITS-1:0]   total;
    logic [SUM_BITS:0]     total_round;
    logic [ACC_BITS-1:0]   rem;
    logic                  accept;

    // The configuration register is always writable.
    assign cfg.ready = 1'b1;

    // Pixels are taken while the queue has room.
    assign pixel.ready = !q_full;
    assign accept      = pixel.valid && pixel.ready;

    // Reduce the channels and append the packed pixel to the leftover bits.
    always_comb
    begin
        w    = eff_width(keep_width_reg);
        drop = CFG_BITS'(BYTE_BITS) - w;
        r    = pixel.red   >> drop;
        g    = pixel.green >> drop;
        b    = pixel.blue  >> drop;
        packed_px = PACK_BITS'(r)
                  | (PACK_BITS'(g) << w)
                  | (PACK_BITS'(b) << {w, 1'b0});
        acc   = ACC_BITS'(pending_bits_reg) | (ACC_BITS'(packed_px) << pending_count_reg);
        total = SUM_BITS'(pending_count_reg) + SUM_BITS'(NUM_CHANNELS) * SUM_BITS'(w);
        total_round = {1'b0, total} + (SUM_BITS+1)'(BYTE_BITS - 1);
    end

    // Build the queue entry; a last pixel rounds up so the partial byte goes out.
    always_comb
    begin
        q_entry.acc  = acc;
        q_entry.last = pixel.last_pixel;
        if (pixel.last_pixel)
        begin
            q_entry.nbytes = NBYTE_BITS'(total_round >> 3);
        end
        else
        begin
            q_entry.nbytes = NBYTE_BITS'(total >> 3);
        end
        q_push = accept && (q_entry.nbytes != '0);
    end

    // Leftover bits after the full bytes; bits above the total are already zero.
    always_comb
    begin
        rem = acc >> {total[SUM_BITS-1:3], 3'b000};
        if (pixel.last_pixel)
        begin
            pending_bits_next  = '0;
            pending_count_next = '0;
        end
        else
        begin
            pending_bits_next  = rem[PEND_BITS-1:0];
            pending_count_next = total[PCNT_BITS-1:0];
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_width_reg    <= KEEP_WIDTH_RESET;
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                keep_width_reg <= cfg.data;
            end
            if (accept)
            begin
                pending_bits_reg  <= pending_bits_next;
                pending_count_reg <= pending_count_next;
            end
        end
    end

endmodule

>>> hw/rtl/ppk_queue.sv
// ----------------------------------------------------------------------------
// ppk_queue: short entry queue between front and back
// A small circular buffer of packed pixels; head entry is always visible.
// ----------------------------------------------------------------------------
module ppk_queue import ppk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ppk_entry_t  push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output ppk_entry_t  head_entry
);

    ppk_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push, do_pop;

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/ppk_back.sv
// ----------------------------------------------------------------------------
// ppk_back: byte emitter
// Takes entries from the queue and sends their bytes one per cycle, while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module ppk_back import ppk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  ppk_entry_t  head_entry,
    output logic        pop,
    ppk_byte_if.source  packed_out
);

    logic [ACC_BITS-1:0]   cur_acc_reg;
    logic [NBYTE_BITS-1:0] cur_left_reg;
    logic                  cur_last_reg;
    logic                  out_valid_reg;
    logic [BYTE_BITS-1:0]  data_byte_reg;
    logic                  last_byte_reg;
    logic                  out_free, cur_active, emit, final_byte;

    assign packed_out.valid     = out_valid_reg;
    assign packed_out.data_byte = data_byte_reg;
    assign packed_out.last_byte = last_byte_reg;

    // A byte moves out when the output stage is empty or being drained.
    assign out_free   = !out_valid_reg || packed_out.ready;
    assign cur_active = (cur_left_reg != '0);
    assign emit       = cur_active && out_free;
    assign final_byte = (cur_left_reg == NBYTE_BITS'(1));
    assign pop        = head_valid && (!cur_active || (emit && final_byte));

    // Working entry: load from the queue, or shift out one byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_left_reg <= '0;
        end
        else if (pop)
        begin
            cur_left_reg <= head_entry.nbytes;
        end
        else if (emit)
        begin
            cur_left_reg <= cur_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_acc_reg  <= head_entry.acc;
            cur_last_reg <= head_entry.last;
        end
        else if (emit)
        begin
            cur_acc_reg <= cur_acc_reg >> BYTE_BITS;
        end
    end

    // Output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (packed_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_byte_reg <= cur_acc_reg[BYTE_BITS-1:0];
            last_byte_reg <= cur_last_reg && final_byte;
        end
    end

endmodule

>>> hw/rtl/packed_rgb_pixel_packer.sv
// ----------------------------------------------------------------------------
// packed_rgb_pixel_packer: reduced-depth RGB bit packer
// Packs the configured number of top bits of each channel into an LSB-first
// byte stream and flushes the partial byte on the last pixel of an image.
// ----------------------------------------------------------------------------
// A pixel is accepted whenever the two-entry queue has room, and the byte
// output runs at one byte per cycle while packed_out.ready does not stall
// it, so the sustained pixel rate is set by the bytes each pixel completes:
// about three eighths of the kept width per channel, three bytes at eight
// bits per channel. The one-byte-wide output sets that limit. A width write
// takes effect from the next pixel; leftover bits carry across pixels until
// the last pixel flushes them.
module packed_rgb_pixel_packer import ppk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ppk_pixel_if.sink   pixel,
    ppk_cfg_if.sink     cfg,
    ppk_byte_if.source  packed_out
);

    logic       q_full, q_push, q_pop, q_head_valid;
    ppk_entry_t q_entry, q_head;

    // Intake and packing.
    ppk_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    // Queue between front and back.
    ppk_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    // Byte emitter.
    ppk_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .packed_out (packed_out)
    );

endmodule
